[src/keyframe_bracket_lookup_unit_defines.svh]
// Assertion macros for the keyframe bracket lookup unit.
// Included by the top level; depends on nothing else.
`ifndef KEYFRAME_BRACKET_LOOKUP_UNIT_DEFINES_SVH
`define KEYFRAME_BRACKET_LOOKUP_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define KBL_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define KBL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/kbl_pkg.sv]
// Shared types and constants of the keyframe bracket lookup unit.
// Used by the key search unit and the top level.
`default_nettype none

package kbl_pkg;

    localparam int CMD_W      = 2;
    localparam int HASH_W     = 32;
    localparam int TRACK_W    = 2;
    localparam int KEY_TIME_W = 32;
    localparam int STATUS_W   = 3;
    localparam int SLOT_W     = 5;
    localparam int IDX_W      = 7;
    localparam int NUM_TRACKS = 3;

    localparam int MAX_NODES_DEF = 32;
    localparam int MAX_KEYS_DEF  = 128;
    localparam int TIME_BITS_DEF = 32;

    localparam logic [TRACK_W-1:0] TRK_POS   = 2'd0;
    localparam logic [TRACK_W-1:0] TRK_ROT   = 2'd1;
    localparam logic [TRACK_W-1:0] TRK_SCALE = 2'd2;

    typedef enum logic [CMD_W-1:0] {
        CMD_NODE  = 2'd0,
        CMD_KEY   = 2'd1,
        CMD_QUERY = 2'd2,
        CMD_NOP   = 2'd3
    } t_kbl_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 3'd0,
        ST_NOT_FOUND  = 3'd1,
        ST_TABLE_FULL = 3'd2,
        ST_TRACK_FULL = 3'd3,
        ST_NO_NODE    = 3'd4,
        ST_EMPTY      = 3'd5
    } t_kbl_status;

    typedef struct packed {
        t_kbl_cmd               cmd;
        logic [HASH_W-1:0]      node_hash;
        logic [TRACK_W-1:0]     track;
        logic [KEY_TIME_W-1:0]  key_time;
        logic [KEY_TIME_W-1:0]  anim_time;
    } t_kbl_req;

    typedef struct packed {
        t_kbl_status        status;
        logic [SLOT_W-1:0]  node_slot;
        logic [IDX_W-1:0]   pos_first;
        logic [IDX_W-1:0]   pos_second;
        logic [IDX_W-1:0]   rot_first;
        logic [IDX_W-1:0]   rot_second;
        logic [IDX_W-1:0]   scale_first;
        logic [IDX_W-1:0]   scale_second;
    } t_kbl_rsp;

endpackage

`default_nettype wire

[src/kbl_stream_if.sv]
// Valid/ready stream interface carrying one request or result payload.
// The payload type is set per instance, normally a struct from kbl_pkg.
`default_nettype none

interface kbl_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[src/kbl_key_search.sv]
// Key time store and bracketing search for one track at a time.
// Holds the key time memory and a key comparison shared by all search steps; uses kbl_pkg.
`default_nettype none

module kbl_key_search
    import kbl_pkg::*;
#(
    parameter int MAX_NODES = MAX_NODES_DEF,
    parameter int MAX_KEYS  = MAX_KEYS_DEF,
    parameter int TW        = TIME_BITS_DEF,
    localparam int ROWS     = NUM_TRACKS * MAX_NODES,
    localparam int RW       = $clog2(ROWS),
    localparam int KW       = $clog2(MAX_KEYS),
    localparam int CW       = $clog2(MAX_KEYS + 1)
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_wr_en,
    input  wire logic [RW-1:0] i_wr_row,
    input  wire logic [KW-1:0] i_wr_idx,
    input  wire logic [TW-1:0] i_wr_time,
    input  wire logic          i_start,
    input  wire logic [RW-1:0] i_row,
    input  wire logic [CW-1:0] i_count,
    input  wire logic [TW-1:0] i_time,
    output logic               o_done,
    output logic [KW-1:0]      o_first,
    output logic [KW-1:0]      o_second
);

    localparam int DEPTH = ROWS * (2 ** KW);

    typedef enum logic [5:0] {
        K_IDLE  = 6'b000001,
        K_LO    = 6'b000010,
        K_HI    = 6'b000100,
        K_PROBE = 6'b001000,
        K_CMP   = 6'b010000,
        K_FIN   = 6'b100000
    } t_ks_state;

    t_ks_state       r_state, n_state;
    logic [RW-1:0]   r_row, n_row;
    logic [CW-1:0]   r_n, n_n;
    logic [TW-1:0]   r_t, n_t;
    logic [CW-1:0]   r_first, n_first;
    logic [CW-1:0]   r_span, n_span;
    logic [CW-1:0]   r_probe, n_probe;
    logic [CW-1:0]   r_step, n_step;
    logic [KW-1:0]   r_f, n_f;

    logic [TW-1:0]   r_key_mem [DEPTH];
    logic [TW-1:0]   r_key_rd;
    logic [RW+KW-1:0] rd_addr;

    logic            key_lt;
    logic            key_eq;
    logic [CW-1:0]   n_m1;
    logic [CW-1:0]   half;
    logic [CW-1:0]   probe;
    logic [CW-1:0]   first_m1;
    logic [CW-1:0]   f_inc;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_key_mem[{i_wr_row, i_wr_idx}] <= i_wr_time;
        end
        r_key_rd <= r_key_mem[rd_addr];
    end

    assign key_lt   = r_key_rd < r_t;
    assign key_eq   = r_key_rd == r_t;
    assign n_m1     = r_n - 1'b1;
    assign half     = r_span >> 1;
    assign probe    = r_first + half;
    assign first_m1 = r_first - 1'b1;
    assign f_inc    = CW'(r_f) + 1'b1;

    always_comb begin
        case (r_state)
            K_IDLE:  rd_addr = {i_row, {KW{1'b0}}};
            K_LO:    rd_addr = {r_row, n_m1[KW-1:0]};
            K_PROBE: rd_addr = {r_row, probe[KW-1:0]};
            default: rd_addr = {r_row, {KW{1'b0}}};
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_row   = r_row;
        n_n     = r_n;
        n_t     = r_t;
        n_first = r_first;
        n_span  = r_span;
        n_probe = r_probe;
        n_step  = r_step;
        n_f     = r_f;
        case (r_state)
            K_IDLE: begin
                if (i_start) begin
                    n_row   = i_row;
                    n_n     = i_count;
                    n_t     = i_time;
                    n_state = K_LO;
                end
            end
            K_LO: begin
                if (!key_lt) begin
                    n_f     = '0;
                    n_state = K_FIN;
                end else begin
                    n_state = K_HI;
                end
            end
            K_HI: begin
                if (key_lt || key_eq) begin
                    n_f     = n_m1[KW-1:0];
                    n_state = K_FIN;
                end else begin
                    n_first = '0;
                    n_span  = r_n;
                    n_state = K_PROBE;
                end
            end
            K_PROBE: begin
                if (r_span == '0) begin
                    n_f     = (r_first == '0) ? '0 : first_m1[KW-1:0];
                    n_state = K_FIN;
                end else begin
                    n_probe = probe;
                    n_step  = half;
                    n_state = K_CMP;
                end
            end
            K_CMP: begin
                if (key_lt || key_eq) begin
                    n_first = r_probe + 1'b1;
                    n_span  = r_span - r_step - 1'b1;
                end else begin
                    n_span  = r_step;
                end
                n_state = K_PROBE;
            end
            K_FIN: begin
                n_state = K_IDLE;
            end
            default: begin
                n_state = K_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= K_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_row   <= n_row;
        r_n     <= n_n;
        r_t     <= n_t;
        r_first <= n_first;
        r_span  <= n_span;
        r_probe <= n_probe;
        r_step  <= n_step;
        r_f     <= n_f;
    end

    assign o_done   = (r_state == K_FIN);
    assign o_first  = r_f;
    assign o_second = (f_inc < r_n) ? f_inc[KW-1:0] : r_f;

endmodule

`default_nettype wire

[src/keyframe_bracket_lookup_unit.sv]
// Top level of the keyframe bracket lookup unit: node table, key counts,
// command sequencer and result register. Uses kbl_pkg, kbl_stream_if and
// kbl_key_search.
//
//   Port     Dir  Payload    Function
//   i_req    in   t_kbl_req  append node, append key time or query
//   o_rsp    out  t_kbl_rsp  one result for every request
//
// Append and no-op requests go to S_DONE and load the output register once it is free.
// A query scans the node table at one node per cycle, then searches the three
// tracks one after another in the key search unit, which checks the first and
// last keys of a track before it runs a binary search.
// The request side is ready only while the sequencer is idle; a result that
// waits in the output register does not block the next request.
// Reset clears the node count, the key counts, the state machines and the output valid flag; no clearing pass is run.
`default_nettype none

`include "keyframe_bracket_lookup_unit_defines.svh"

module keyframe_bracket_lookup_unit
    import kbl_pkg::*;
#(
    parameter int MAX_NODES = MAX_NODES_DEF,
    parameter int MAX_KEYS  = MAX_KEYS_DEF,
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    kbl_stream_if.sink  i_req,
    kbl_stream_if.source o_rsp
);

    localparam int SW   = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int NW   = $clog2(MAX_NODES + 1);
    localparam int KW   = $clog2(MAX_KEYS);
    localparam int CW   = $clog2(MAX_KEYS + 1);
    localparam int ROWS = NUM_TRACKS * MAX_NODES;
    localparam int RW   = $clog2(ROWS);
    localparam int TW   = (TIME_BITS < KEY_TIME_W) ? TIME_BITS : KEY_TIME_W;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_SCAN = 7'b0000010,
        S_CNT  = 7'b0000100,
        S_TRK  = 7'b0001000,
        S_SRCH = 7'b0010000,
        S_DONE = 7'b0100000,
        S_HOLD = 7'b1000000
    } t_kbl_state;

    typedef logic [NUM_TRACKS-1:0][CW-1:0] t_cnt_row;

    t_kbl_state      r_state, n_state;
    logic [NW-1:0]   r_total, n_total;
    logic [NW-1:0]   r_idx, n_idx;
    logic            r_pend, n_pend;
    logic [SW-1:0]   r_pidx, n_pidx;
    logic [SW-1:0]   r_slot, n_slot;
    logic [1:0]      r_trk, n_trk;
    logic [HASH_W-1:0] r_hash, n_hash;
    logic [TW-1:0]   r_time, n_time;
    t_cnt_row        r_last_cnt, n_last_cnt;
    t_kbl_rsp        r_res, n_res;
    t_kbl_rsp        r_out, n_out;
    logic            r_out_vld, n_out_vld;

    logic [HASH_W-1:0] r_hash_mem [MAX_NODES];
    logic [HASH_W-1:0] r_hash_rd;
    t_cnt_row        r_cnt_mem [MAX_NODES];
    t_cnt_row        r_cnt_rd;

    logic            hash_we;
    logic            cnt_we;
    logic [SW-1:0]   cnt_wr_addr;
    t_cnt_row        cnt_wr_data;
    logic            key_we;
    logic [RW-1:0]   key_row;
    logic            srch_start;
    logic            srch_done;
    logic [KW-1:0]   srch_first;
    logic [KW-1:0]   srch_second;
    logic [RW-1:0]   qry_row;
    logic [SW-1:0]   last_slot;
    logic            store_trk;
    logic [KW-1:0]   st_first;
    logic [KW-1:0]   st_second;
    logic            last_trk;

    always_ff @(posedge i_clk) begin
        if (hash_we) begin
            r_hash_mem[r_total[SW-1:0]] <= i_req.data.node_hash;
        end
        r_hash_rd <= r_hash_mem[r_idx[SW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (cnt_we) begin
            r_cnt_mem[cnt_wr_addr] <= cnt_wr_data;
        end
        r_cnt_rd <= r_cnt_mem[r_slot];
    end

    assign last_slot = SW'(r_total - 1'b1);
    assign key_row   = RW'(last_slot) * RW'(NUM_TRACKS) + RW'(i_req.data.track);
    assign qry_row   = RW'(r_slot) * RW'(NUM_TRACKS) + RW'(r_trk);
    assign last_trk  = (r_trk == 2'(NUM_TRACKS - 1));

    kbl_key_search #(
        .MAX_NODES (MAX_NODES),
        .MAX_KEYS  (MAX_KEYS),
        .TW        (TW)
    ) u_search (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (key_we),
        .i_wr_row  (key_row),
        .i_wr_idx  (r_last_cnt[i_req.data.track][KW-1:0]),
        .i_wr_time (i_req.data.key_time[TW-1:0]),
        .i_start   (srch_start),
        .i_row     (qry_row),
        .i_count   (r_cnt_rd[r_trk]),
        .i_time    (r_time),
        .o_done    (srch_done),
        .o_first   (srch_first),
        .o_second  (srch_second)
    );

    always_comb begin
        n_state    = r_state;
        n_total    = r_total;
        n_idx      = r_idx;
        n_pend     = r_pend;
        n_pidx     = r_pidx;
        n_slot     = r_slot;
        n_trk      = r_trk;
        n_hash     = r_hash;
        n_time     = r_time;
        n_last_cnt = r_last_cnt;
        n_res      = r_res;
        hash_we    = 1'b0;
        cnt_we     = 1'b0;
        cnt_wr_addr = last_slot;
        cnt_wr_data = '0;
        key_we     = 1'b0;
        srch_start = 1'b0;
        store_trk  = 1'b0;
        st_first   = '0;
        st_second  = '0;

        case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_res   = '0;
                    n_state = S_DONE;
                    case (i_req.data.cmd)
                        CMD_NODE: begin
                            if (r_total >= NW'(MAX_NODES)) begin
                                n_res.status = ST_TABLE_FULL;
                            end else begin
                                hash_we         = 1'b1;
                                cnt_we          = 1'b1;
                                cnt_wr_addr     = r_total[SW-1:0];
                                n_last_cnt      = '0;
                                n_res.node_slot = SLOT_W'(r_total);
                                n_total         = r_total + 1'b1;
                            end
                        end
                        CMD_KEY: begin
                            if (r_total == '0) begin
                                n_res.status = ST_NO_NODE;
                            end else if (i_req.data.track > TRK_SCALE) begin
                                n_res.status = ST_TRACK_FULL;
                            end else if (r_last_cnt[i_req.data.track] >= CW'(MAX_KEYS)) begin
                                n_res.status = ST_TRACK_FULL;
                            end else begin
                                key_we = 1'b1;
                                cnt_we = 1'b1;
                                n_last_cnt[i_req.data.track] =
                                    r_last_cnt[i_req.data.track] + 1'b1;
                                cnt_wr_data = n_last_cnt;
                            end
                        end
                        CMD_QUERY: begin
                            n_hash  = i_req.data.node_hash;
                            n_time  = i_req.data.anim_time[TW-1:0];
                            n_idx   = '0;
                            n_pend  = 1'b0;
                            n_state = S_SCAN;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (r_pend && (r_hash_rd == r_hash)) begin
                    n_slot          = r_pidx;
                    n_res.node_slot = SLOT_W'(r_pidx);
                    n_state         = S_CNT;
                end else if (!r_pend && (r_idx == r_total)) begin
                    n_res.status = ST_NOT_FOUND;
                    n_state      = S_DONE;
                end else if (r_idx < r_total) begin
                    n_pend = 1'b1;
                    n_pidx = r_idx[SW-1:0];
                    n_idx  = r_idx + 1'b1;
                end else begin
                    n_pend = 1'b0;
                end
            end
            S_CNT: begin
                n_trk   = TRK_POS;
                n_state = S_TRK;
            end
            S_TRK: begin
                if (r_cnt_rd[r_trk] == '0) begin
                    n_res.status = ST_EMPTY;
                    store_trk    = 1'b1;
                end else begin
                    srch_start = 1'b1;
                    n_state    = S_SRCH;
                end
            end
            S_SRCH: begin
                if (srch_done) begin
                    store_trk = 1'b1;
                    st_first  = srch_first;
                    st_second = srch_second;
                end
            end
            S_DONE: begin
                if (!r_out_vld || o_rsp.ready) begin
                    n_state = S_IDLE;
                end
            end
            S_HOLD: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (store_trk) begin
            case (r_trk)
                TRK_POS: begin
                    n_res.pos_first  = IDX_W'(st_first);
                    n_res.pos_second = IDX_W'(st_second);
                end
                TRK_ROT: begin
                    n_res.rot_first  = IDX_W'(st_first);
                    n_res.rot_second = IDX_W'(st_second);
                end
                TRK_SCALE: begin
                    n_res.scale_first  = IDX_W'(st_first);
                    n_res.scale_second = IDX_W'(st_second);
                end
                default: begin
                    n_res = r_res;
                end
            endcase
            if (last_trk) begin
                n_state = S_DONE;
            end else begin
                n_trk   = r_trk + 1'b1;
                n_state = S_TRK;
            end
        end
    end

    always_comb begin
        n_out     = r_out;
        n_out_vld = r_out_vld && !o_rsp.ready;
        if ((r_state == S_DONE) && (!r_out_vld || o_rsp.ready)) begin
            n_out     = r_res;
            n_out_vld = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_total    <= '0;
            r_pend     <= 1'b0;
            r_last_cnt <= '0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_total    <= n_total;
            r_pend     <= n_pend;
            r_last_cnt <= n_last_cnt;
            r_out_vld  <= n_out_vld;
        end
        r_idx  <= n_idx;
        r_pidx <= n_pidx;
        r_slot <= n_slot;
        r_trk  <= n_trk;
        r_hash <= n_hash;
        r_time <= n_time;
        r_res  <= n_res;
        r_out  <= n_out;
    end

    assign i_req.ready = (r_state == S_IDLE);
    assign o_rsp.valid = r_out_vld;
    assign o_rsp.data  = r_out;

    `KBL_ASSERT_IMPL(a_total_bound, i_clk, i_rst_n, 1'b1, r_total <= NW'(MAX_NODES), "node count beyond table size")
    `KBL_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, i_req.valid && i_req.ready, (r_state == S_DONE) || (r_state == S_SCAN), "accepted request did not start")
    `KBL_ASSERT_NEXT(a_done_loads, i_clk, i_rst_n, (r_state == S_DONE) && (!r_out_vld || o_rsp.ready), r_out_vld && (r_state == S_IDLE), "result not loaded")
    `KBL_ASSERT_IMPL(a_search_owned, i_clk, i_rst_n, srch_done, r_state == S_SRCH, "search finished outside a query")

endmodule

`default_nettype wire
